// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define SKT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define SKT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/skt_pkg.sv =====
package skt_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic               command;
		logic [15:0]        key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [15:0]        entry_key;
		logic signed [31:0] entry_value;
		logic [4:0]         entry_count;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

// ===== hdl/skt_ctrl.sv =====
`include "assert_macros.svh"

module skt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output skt_pkg::ctrl_cmd_t cmd
);
	import skt_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd.exec  = (state_q == S_HOLD) && out_free;
	assign req_stall = (state_q == S_HOLD) && !cmd.exec;
	assign accept    = req_valid && !req_stall;
	assign cmd.load  = accept;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (cmd.exec && !accept) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`SKT_ASSERT_NXT(a_accept_holds, clk, arst_n, accept, state_q == S_HOLD)
	`SKT_ASSERT_NXT(a_exec_drains, clk, arst_n, cmd.exec && !accept, state_q == S_IDLE)
	`SKT_ASSERT_NXT(a_exec_shows, clk, arst_n, cmd.exec, rsp_valid)

endmodule

// ===== hdl/skt_datapath.sv =====
`include "assert_macros.svh"

module skt_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  skt_pkg::ctrl_cmd_t cmd,
	input  skt_pkg::req_t      req,
	output skt_pkg::rsp_t      rsp
);
	import skt_pkg::*;

	req_t                        req_q;
	rsp_t                        rsp_q;
	logic [KEY_BITS-1:0]         key_q [CAPACITY];
	logic signed [VALUE_BITS-1:0] val_q [CAPACITY];
	logic [CNT_W-1:0]            count_q;

	logic [KEY_BITS-1:0]          k;
	logic signed [VALUE_BITS-1:0] v;
	logic [CAPACITY-1:0]          lt;
	logic [CAPACITY-1:0]          eq;
	logic [CAPACITY-1:0]          prev_lt;
	logic [CAPACITY-1:0]          ins;
	logic [CAPACITY-1:0]          shf;
	logic [KEY_BITS-1:0]          prev_key [CAPACITY];
	logic signed [VALUE_BITS-1:0] prev_val [CAPACITY];
	logic                         hit;
	logic                         full;
	logic                         empty;
	logic [IDX_W-1:0]             top_idx;
	logic                         do_insert;
	logic                         do_remove;
	logic [CNT_W-1:0]             count_nx;
	rsp_t                         rsp_nx;

	assign k       = KEY_BITS'(req_q.key);
	assign v       = VALUE_BITS'(req_q.value);
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign empty   = (count_q == '0);
	assign top_idx = IDX_W'(count_q - 1'b1);
	assign hit     = |eq;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt[i] = (CNT_W'(i) < count_q) && (key_q[i] < k);
			eq[i] = (CNT_W'(i) < count_q) && (key_q[i] == k);
		end
		prev_lt[0]  = 1'b1;
		prev_key[0] = k;
		prev_val[0] = v;
		for (int i = 1; i < CAPACITY; i++) begin
			prev_lt[i]  = lt[i-1];
			prev_key[i] = key_q[i-1];
			prev_val[i] = val_q[i-1];
		end
		for (int i = 0; i < CAPACITY; i++) begin
			ins[i] = prev_lt[i] && !lt[i];
			shf[i] = !prev_lt[i] && (CNT_W'(i) <= count_q);
		end
	end

	always_comb begin
		do_insert = 1'b0;
		do_remove = 1'b0;
		count_nx  = count_q;
		rsp_nx    = '0;
		if (req_q.command == CMD_REMOVE) begin
			if (empty) begin
				rsp_nx.status = ST_EMPTY;
			end else begin
				do_remove          = 1'b1;
				count_nx           = count_q - 1'b1;
				rsp_nx.status      = ST_REMOVED;
				rsp_nx.entry_key   = 16'(key_q[top_idx]);
				rsp_nx.entry_value = 32'(val_q[top_idx]);
			end
		end else if (hit) begin
			rsp_nx.status      = ST_UPDATED;
			rsp_nx.entry_key   = 16'(k);
			rsp_nx.entry_value = 32'(v);
		end else if (full) begin
			rsp_nx.status = ST_FULL;
		end else begin
			do_insert          = 1'b1;
			count_nx           = count_q + 1'b1;
			rsp_nx.status      = ST_INSERTED;
			rsp_nx.entry_key   = 16'(k);
			rsp_nx.entry_value = 32'(v);
		end
		rsp_nx.entry_count = 5'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_nx;
			for (int i = 0; i < CAPACITY; i++) begin
				if (req_q.command == CMD_INSERT && hit && eq[i]) begin
					val_q[i] <= v;
				end else if (do_insert && ins[i]) begin
					key_q[i] <= k;
					val_q[i] <= v;
				end else if (do_insert && shf[i]) begin
					key_q[i] <= prev_key[i];
					val_q[i] <= prev_val[i];
				end
			end
		end
	end

	assign rsp = rsp_q;

	`SKT_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SKT_ASSERT_NXT(a_remove_count, clk, arst_n, cmd.exec && do_remove,
		count_q == $past(count_q) - 1'b1)
	`SKT_ASSERT_IMP(a_full_reject, clk, arst_n, cmd.exec && rsp_nx.status == ST_FULL,
		count_q == CNT_W'(CAPACITY) && !hit)

endmodule

// ===== hdl/sorted_keyed_table_upsert.sv =====
// Channel  Handshake             Payload
// req      req_valid/req_stall   req   : command, key, value
// rsp      rsp_valid/rsp_stall   rsp   : status, entry_key, entry_value, entry_count
//
// An item is registered on acceptance and executed once the output register is
// free; the compare-and-shift over the register table is done in the execute
// step, so sustained rate is one item per cycle while the result is not stalled.
// arst_n clears the entry count and handshake state; the table needs no clearing.
// A stalled result holds the output register and, in turn, the held item.
module sorted_keyed_table_upsert (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  skt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output skt_pkg::rsp_t rsp
);
	import skt_pkg::*;

	ctrl_cmd_t cmd;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	skt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
